// ----- design/pvt_pkg.sv -----
package pvt_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegW = 64;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned CoordW = 32;
  localparam int unsigned AccW = 50;
  localparam int unsigned FracW = 16;
  localparam int unsigned QuoW = 33;
  localparam int unsigned DivSteps = 3;

  localparam logic [RegW-1:0] ResetM [NumRegs] = '{
    64'h0000_0000_0001_0000, 64'h0,
    64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000,
    64'h0, 64'h0001_0000_0000_0000
  };

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [AccW-1:0] acc_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    acc_t x;
    acc_t y;
    acc_t z;
    acc_t w;
  } accs_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   w_zero;
  } result_t;

  function automatic coord_t sat32(input acc_t v);
    if (v > acc_t'(64'sh7FFF_FFFF)) begin
      return coord_t'(32'h7FFF_FFFF);
    end else if (v < -acc_t'(64'sh8000_0000)) begin
      return coord_t'(32'h8000_0000);
    end
    return coord_t'(v);
  endfunction

endpackage

// ----- design/pvt_mac.sv -----
module pvt_mac (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  pvt_pkg::point_t        in_pt,
  input  logic [pvt_pkg::RegW-1:0] m [pvt_pkg::NumRegs],
  output logic                   out_valid,
  output pvt_pkg::accs_t         out_acc
);

  logic signed [63:0] prod_r [12];
  logic signed [31:0] trans_r [4];
  logic               v1_r;
  logic signed [pvt_pkg::AccW-1:0] sum [4];

  function automatic logic signed [31:0] entry(input logic [pvt_pkg::RegW-1:0] mm
                                               [pvt_pkg::NumRegs],
                                               input int r, input int c);
    logic [63:0] reg_v;
    reg_v = mm[r*2 + c/2];
    return (c % 2 == 1) ? reg_v[63:32] : reg_v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      out_valid <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        prod_r[c]     <= in_pt.x * entry(m, 0, c);
        prod_r[4 + c] <= in_pt.y * entry(m, 1, c);
        prod_r[8 + c] <= in_pt.z * entry(m, 2, c);
        trans_r[c]    <= entry(m, 3, c);
      end
      out_acc.x <= sum[0];
      out_acc.y <= sum[1];
      out_acc.z <= sum[2];
      out_acc.w <= sum[3];
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c] = pvt_pkg::AccW'(prod_r[c] >>> pvt_pkg::FracW)
             + pvt_pkg::AccW'(prod_r[4 + c] >>> pvt_pkg::FracW)
             + pvt_pkg::AccW'(prod_r[8 + c] >>> pvt_pkg::FracW)
             + pvt_pkg::AccW'(trans_r[c]);
    end
  end

endmodule

// ----- design/pvt_div.sv -----
module pvt_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  pvt_pkg::accs_t         in_acc,
  output logic                   out_valid,
  output pvt_pkg::result_t       out_res
);

  localparam int unsigned Stages = (pvt_pkg::QuoW + pvt_pkg::DivSteps - 1) / pvt_pkg::DivSteps;
  localparam int unsigned DW = pvt_pkg::AccW;
  localparam int unsigned RW = DW + 1;

  logic [Stages:0]   v_r;
  logic [RW-1:0]     rem_r [Stages+1][3];
  logic [pvt_pkg::QuoW-1:0] quo_r [Stages+1][3];
  logic [DW-1:0]     num_r [Stages+1][3];
  logic [2:0]        neg_r [Stages+1];
  logic [DW-1:0]     d_r [Stages+1];
  logic              wz_r [Stages+1];
  pvt_pkg::acc_t     raw_r [Stages+1][3];
  logic [RW-1:0]     rem_n [Stages][3];
  logic [pvt_pkg::QuoW-1:0] quo_n [Stages][3];
  logic [DW-1:0]     num_n [Stages][3];
  pvt_pkg::acc_t     nums [3];
  logic [DW+pvt_pkg::FracW-1:0] dividend [3];

  assign nums[0] = in_acc.x;
  assign nums[1] = in_acc.y;
  assign nums[2] = in_acc.z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Stages-1:0], in_valid};
    end
  end

  always_comb begin
    for (int s = 0; s < Stages; s++) begin
      for (int k = 0; k < 3; k++) begin
        rem_n[s][k] = rem_r[s][k];
        quo_n[s][k] = quo_r[s][k];
        num_n[s][k] = num_r[s][k];
        for (int b = 0; b < pvt_pkg::DivSteps; b++) begin
          rem_n[s][k] = {rem_n[s][k][RW-2:0], num_n[s][k][DW-1]};
          num_n[s][k] = {num_n[s][k][DW-2:0], 1'b0};
          if (rem_n[s][k] >= {1'b0, d_r[s]}) begin
            rem_n[s][k] = rem_n[s][k] - {1'b0, d_r[s]};
            quo_n[s][k] = {quo_n[s][k][pvt_pkg::QuoW-2:0], 1'b1};
          end else begin
            quo_n[s][k] = {quo_n[s][k][pvt_pkg::QuoW-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dividend[k] = {(nums[k][DW-1] ? DW'(-nums[k]) : DW'(nums[k])),
                     {pvt_pkg::FracW{1'b0}}};
    end
  end

  // Stage 0 loads the dividend's upper bits into the remainder so that its low QuoW bits remain for the shift stages.
  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]  <= in_acc.w[DW-1] ? DW'(-in_acc.w) : DW'(in_acc.w);
      wz_r[0] <= (in_acc.w == '0);
      for (int k = 0; k < 3; k++) begin
        rem_r[0][k] <= RW'(dividend[k][DW+pvt_pkg::FracW-1:pvt_pkg::QuoW]);
        num_r[0][k] <= {dividend[k][pvt_pkg::QuoW-1:0], {(DW-pvt_pkg::QuoW){1'b0}}};
        quo_r[0][k] <= '0;
        neg_r[0][k] <= nums[k][DW-1] ^ in_acc.w[DW-1];
        raw_r[0][k] <= nums[k];
      end
      for (int s = 0; s < Stages; s++) begin
        d_r[s+1]  <= d_r[s];
        wz_r[s+1] <= wz_r[s];
        neg_r[s+1] <= neg_r[s];
        for (int k = 0; k < 3; k++) begin
          rem_r[s+1][k] <= rem_n[s][k];
          quo_r[s+1][k] <= quo_n[s][k];
          num_r[s+1][k] <= num_n[s][k];
          raw_r[s+1][k] <= raw_r[s][k];
        end
      end
    end
  end

  function automatic pvt_pkg::coord_t fin(input logic [RW-1:0] rem,
                                         input logic [pvt_pkg::QuoW-1:0] q,
                                         input logic neg);
    // A high remainder at or above the divisor before the loop means the quotient is far out of range.
    if (rem != '0 || q[pvt_pkg::QuoW-1]) begin
      return neg ? pvt_pkg::coord_t'(32'h8000_0000) : pvt_pkg::coord_t'(32'h7FFF_FFFF);
    end
    if (neg) begin
      return (q > 33'h0_8000_0000) ? pvt_pkg::coord_t'(32'h8000_0000)
                                   : pvt_pkg::coord_t'(-q[31:0]);
    end
    return (q > 33'h0_7FFF_FFFF) ? pvt_pkg::coord_t'(32'h7FFF_FFFF)
                                 : pvt_pkg::coord_t'(q[31:0]);
  endfunction

  logic [RW-1:0] hi_r [Stages+1][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        hi_r[0][k] <= (RW'(dividend[k][DW+pvt_pkg::FracW-1:pvt_pkg::QuoW]) >=
                       {1'b0, (in_acc.w[DW-1] ? DW'(-in_acc.w) : DW'(in_acc.w))})
                      ? RW'(1) : RW'(0);
      end
      for (int s = 0; s < Stages; s++) begin
        for (int k = 0; k < 3; k++) begin
          hi_r[s+1][k] <= hi_r[s][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_r[Stages];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res.w_zero <= wz_r[Stages];
      out_res.x <= wz_r[Stages] ? pvt_pkg::sat32(raw_r[Stages][0])
                 : fin(hi_r[Stages][0], quo_r[Stages][0], neg_r[Stages][0]);
      out_res.y <= wz_r[Stages] ? pvt_pkg::sat32(raw_r[Stages][1])
                 : fin(hi_r[Stages][1], quo_r[Stages][1], neg_r[Stages][1]);
      out_res.z <= wz_r[Stages] ? pvt_pkg::sat32(raw_r[Stages][2])
                 : fin(hi_r[Stages][2], quo_r[Stages][2], neg_r[Stages][2]);
    end
  end

endmodule

// ----- design/projective_vertex_transform.sv -----
// Transforms one Q16.16 point per cycle, unless stalled, by a configured 4x4 matrix and
// divides by w, saturating, with a restoring divider that resolves three quotient bits
// per stage. A full stall freezes the whole pipeline.
module projective_vertex_transform (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [95:0]   in_tdata,   // in_x, in_y, in_z
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [103:0]  out_tdata,  // out_x, out_y, out_z, w_zero, zero fill
  input  logic          cfg_we,
  input  logic [pvt_pkg::RegIdxW-1:0] cfg_index,
  input  logic [pvt_pkg::RegW-1:0]    cfg_data
);

  logic [pvt_pkg::RegW-1:0] m_r [pvt_pkg::NumRegs];
  pvt_pkg::point_t  pt;
  pvt_pkg::accs_t   acc;
  pvt_pkg::result_t res;
  logic acc_v, res_v, en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= pvt_pkg::ResetM;
    end else if (cfg_we) begin
      m_r[cfg_index] <= cfg_data;
    end
  end

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tvalid = res_v;
  assign pt.x = in_tdata[31:0];
  assign pt.y = in_tdata[63:32];
  assign pt.z = in_tdata[95:64];
  assign out_tdata = {7'b0, res.w_zero, res.z, res.y, res.x};

  pvt_mac u_mac (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid), .in_pt(pt),
    .m(m_r), .out_valid(acc_v), .out_acc(acc)
  );

  pvt_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(acc_v), .in_acc(acc),
    .out_valid(res_v), .out_res(res)
  );

endmodule

// ----- design/pvt_checker.sv -----
module pvt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed during stall");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output side");

  a_wz_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[103:97] == 7'b0)
    else $error("fill bits set");

endmodule

bind projective_vertex_transform pvt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
